// ===== rtl/psd_pkg.sv =====
// Package: widths, sequencer states and payload types for the segment direction block.
package psd_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int DIR_FRAC_BITS = 14;
    localparam int DIR_WIDTH     = DIR_FRAC_BITS + 2;
    localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
    localparam int MAG_WIDTH     = COORD_WIDTH;
    localparam int SCALED_WIDTH  = 31;
    localparam int SUM_WIDTH     = 64;
    localparam int ROOT_WIDTH    = 32;
    localparam int SHIFT_WIDTH   = $clog2(MAG_WIDTH + 1);
    localparam int QUOT_WIDTH    = SCALED_WIDTH + DIR_FRAC_BITS + 1;
    localparam int NUM_WIDTH     = QUOT_WIDTH + 1;
    localparam int DEN_WIDTH     = ROOT_WIDTH + 1;
    localparam int ROOT_STEPS    = SUM_WIDTH / 2;
    localparam int STEP_WIDTH    = $clog2(QUOT_WIDTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic                          line_start;
    } point_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic signed [DIR_WIDTH-1:0]   dir_x;
        logic signed [DIR_WIDTH-1:0]   dir_y;
        logic signed [DIR_WIDTH-1:0]   dir_z;
        logic                          zero_segment;
    } result_t;

endpackage

// ===== rtl/psd_stream_if.sv =====
// Interface: valid/ready channel carrying one payload item.
interface psd_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/polyline_segment_direction.sv =====
// Top level: unit direction of each 3D polyline segment, iterative sqrt and divide.
//
// Each input item is one point with a line_start flag; each gives exactly one result item:
// the point unchanged plus the Q1.14 unit vector from the previous point. A line start
// yields a zero direction; a zero-length segment yields zero and raises zero_segment.
// The block works on one item at a time and takes an item whenever the sequencer is idle,
// even while the previous result still waits in the output register. A segment passes
// through capture, a squaring per axis on one shared 31x31 multiplier, 32 square-root steps
// (two radicand bits per step) and a division per axis (one numerator load plus 47
// restoring steps on one shared subtractor), then the output load; the next item is
// taken only once the sequencer is back in idle. A line start or zero segment goes
// from capture straight to the load state, so its result shows at the same time as
// the input is freed. A finished item holds in the load state while the output register
// is full and not being emptied, and the input stalls then.
module polyline_segment_direction (
    input  logic        clk,
    input  logic        rst_n,
    psd_stream_if.sink  in_if,
    psd_stream_if.source out_if
);

    psd_pkg::state_t state_reg, state_next;

    logic signed [psd_pkg::COORD_WIDTH-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    psd_pkg::point_t  pt_reg;
    logic             neg_reg [3];
    logic [psd_pkg::SCALED_WIDTH-1:0] s_reg [3];
    logic [psd_pkg::SUM_WIDTH-1:0]    sum_reg;
    logic [psd_pkg::SUM_WIDTH-1:0]    rem_reg;
    logic [psd_pkg::ROOT_WIDTH-1:0]   root_reg;
    logic [psd_pkg::STEP_WIDTH-1:0]   step_reg;
    logic [1:0]                       axis_reg;
    logic [psd_pkg::NUM_WIDTH-1:0]    num_reg;
    logic [psd_pkg::QUOT_WIDTH-1:0]   quot_reg;
    logic [psd_pkg::DEN_WIDTH:0]      drem_reg;
    logic signed [psd_pkg::DIR_WIDTH-1:0] dir_reg [3];
    psd_pkg::result_t res_reg;
    logic             res_valid_reg;

    logic accept;
    logic res_load;
    assign in_if.ready = (state_reg == psd_pkg::ST_IDLE);
    assign accept      = in_if.valid && in_if.ready;
    assign out_if.valid = res_valid_reg;
    assign out_if.data  = res_reg;
    // load the output register once it is empty or being emptied this cycle
    assign res_load    = (state_reg == psd_pkg::ST_DONE) && (!res_valid_reg || out_if.ready);

    // differences and magnitudes of the incoming point
    logic signed [psd_pkg::DIFF_WIDTH-1:0] d [3];
    logic [psd_pkg::MAG_WIDTH:0] m [3];
    logic [psd_pkg::MAG_WIDTH:0] mmax;
    logic [psd_pkg::SHIFT_WIDTH-1:0] k;
    always_comb
    begin
        d[0] = psd_pkg::DIFF_WIDTH'(in_if.data.point_x) - psd_pkg::DIFF_WIDTH'(prev_x_reg);
        d[1] = psd_pkg::DIFF_WIDTH'(in_if.data.point_y) - psd_pkg::DIFF_WIDTH'(prev_y_reg);
        d[2] = psd_pkg::DIFF_WIDTH'(in_if.data.point_z) - psd_pkg::DIFF_WIDTH'(prev_z_reg);
        for (int i = 0; i < 3; i++)
        begin
            m[i] = d[i][psd_pkg::DIFF_WIDTH-1] ? $unsigned(-d[i]) : $unsigned(d[i]);
        end
        mmax = m[0];
        if (m[1] > mmax) mmax = m[1];
        if (m[2] > mmax) mmax = m[2];
        // leading-one position picks the shared shift
        k = '0;
        for (int b = psd_pkg::SCALED_WIDTH; b <= psd_pkg::MAG_WIDTH; b++)
        begin
            if (mmax[b]) k = psd_pkg::SHIFT_WIDTH'(b - psd_pkg::SCALED_WIDTH + 1);
        end
    end

    // shared multiplier for the squares
    logic [psd_pkg::SCALED_WIDTH-1:0] sq_in;
    logic [2*psd_pkg::SCALED_WIDTH-1:0] sq;
    assign sq_in = s_reg[axis_reg];
    assign sq    = sq_in * sq_in;

    // square root step: two bits of the radicand per cycle
    logic [psd_pkg::SUM_WIDTH-1:0] rem_sh;
    logic [psd_pkg::ROOT_WIDTH+1:0] trial;
    assign rem_sh = {rem_reg[psd_pkg::SUM_WIDTH-3:0], sum_reg[psd_pkg::SUM_WIDTH-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    // restoring division step: (s*2^(F+1) + n) / (2n)
    logic [psd_pkg::DEN_WIDTH:0] dsh, dden;
    assign dsh  = {drem_reg[psd_pkg::DEN_WIDTH-1:0], num_reg[psd_pkg::NUM_WIDTH-1]};
    assign dden = {1'b0, root_reg, 1'b0};

    logic [psd_pkg::QUOT_WIDTH-1:0] qnext;
    logic [psd_pkg::DIR_WIDTH-1:0]  mag_dir;
    always_comb
    begin
        qnext = {quot_reg[psd_pkg::QUOT_WIDTH-2:0], (dsh >= dden)};
        if (qnext > psd_pkg::QUOT_WIDTH'(1 << psd_pkg::DIR_FRAC_BITS))
            mag_dir = psd_pkg::DIR_WIDTH'(1 << psd_pkg::DIR_FRAC_BITS);
        else
            mag_dir = qnext[psd_pkg::DIR_WIDTH-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psd_pkg::ST_IDLE:
                if (accept)
                    state_next = (in_if.data.line_start || mmax == '0)
                               ? psd_pkg::ST_DONE : psd_pkg::ST_SQUARE;
            psd_pkg::ST_SQUARE:
                if (axis_reg == 2'd2) state_next = psd_pkg::ST_ROOT;
            psd_pkg::ST_ROOT:
                if (step_reg == psd_pkg::STEP_WIDTH'(psd_pkg::ROOT_STEPS - 1))
                    state_next = psd_pkg::ST_DIVIDE;
            psd_pkg::ST_DIVIDE:
                if (axis_reg == 2'd2 &&
                    step_reg == psd_pkg::STEP_WIDTH'(psd_pkg::NUM_WIDTH - 1))
                    state_next = psd_pkg::ST_DONE;
            psd_pkg::ST_DONE:
                if (res_load) state_next = psd_pkg::ST_IDLE;
            default:
                state_next = psd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psd_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_if.valid && out_if.ready) res_valid_reg <= 1'b0;
            if (res_load) res_valid_reg <= 1'b1;
            if (accept)
            begin
                prev_x_reg <= in_if.data.point_x;
                prev_y_reg <= in_if.data.point_y;
                prev_z_reg <= in_if.data.point_z;
            end
        end
    end

    // datapath: no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            psd_pkg::ST_IDLE:
                if (accept)
                begin
                    pt_reg   <= in_if.data;
                    axis_reg <= 2'd0;
                    sum_reg  <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= d[i][psd_pkg::DIFF_WIDTH-1];
                        s_reg[i]   <= psd_pkg::SCALED_WIDTH'(m[i] >> k);
                        dir_reg[i] <= '0;
                    end
                end
            psd_pkg::ST_SQUARE:
            begin
                sum_reg  <= sum_reg + psd_pkg::SUM_WIDTH'(sq);
                axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= '0;
            end
            psd_pkg::ST_ROOT:
            begin
                sum_reg <= {sum_reg[psd_pkg::SUM_WIDTH-3:0], 2'b00};
                if (psd_pkg::SUM_WIDTH'(trial) <= rem_sh)
                begin
                    rem_reg  <= rem_sh - psd_pkg::SUM_WIDTH'(trial);
                    root_reg <= {root_reg[psd_pkg::ROOT_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[psd_pkg::ROOT_WIDTH-2:0], 1'b0};
                end
                step_reg <= (step_reg == psd_pkg::STEP_WIDTH'(psd_pkg::ROOT_STEPS - 1))
                          ? '0 : step_reg + 1'b1;
                if (step_reg == psd_pkg::STEP_WIDTH'(psd_pkg::ROOT_STEPS - 1))
                begin
                    // root is final next cycle; load numerator of axis 0 then
                    axis_reg <= 2'd0;
                    quot_reg <= '0;
                    drem_reg <= '0;
                    num_reg  <= '0;
                end
            end
            psd_pkg::ST_DIVIDE:
            begin
                if (step_reg == '0 && quot_reg == '0 && drem_reg == '0 && num_reg == '0)
                begin
                    // first cycle of a division: load numerator
                    num_reg <= ({1'b0, s_reg[axis_reg], {(psd_pkg::DIR_FRAC_BITS+1){1'b0}}})
                             + psd_pkg::NUM_WIDTH'(root_reg);
                end
                else
                begin
                    num_reg  <= {num_reg[psd_pkg::NUM_WIDTH-2:0], 1'b0};
                    drem_reg <= (dsh >= dden) ? dsh - dden : dsh;
                    quot_reg <= qnext;
                    if (step_reg == psd_pkg::STEP_WIDTH'(psd_pkg::NUM_WIDTH - 1))
                    begin
                        dir_reg[axis_reg] <= neg_reg[axis_reg] ? -$signed(mag_dir)
                                                               : $signed(mag_dir);
                        axis_reg <= axis_reg + 2'd1;
                        step_reg <= '0;
                        quot_reg <= '0;
                        drem_reg <= '0;
                        num_reg  <= '0;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
            end
            psd_pkg::ST_DONE:
                if (res_load)
                begin
                    res_reg.out_x        <= pt_reg.point_x;
                    res_reg.out_y        <= pt_reg.point_y;
                    res_reg.out_z        <= pt_reg.point_z;
                    res_reg.dir_x        <= dir_reg[0];
                    res_reg.dir_y        <= dir_reg[1];
                    res_reg.dir_z        <= dir_reg[2];
                    res_reg.zero_segment <= !pt_reg.line_start &&
                                            s_reg[0] == '0 && s_reg[1] == '0 &&
                                            s_reg[2] == '0;
                end
            default: ;
        endcase
    end

endmodule

// ===== rtl/psd_checker.sv =====
// Checker: port-level properties of the segment direction block, bound to the top level.
module psd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input psd_pkg::result_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after taking an item");
    a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_segment |->
        out_data.dir_x == 0 && out_data.dir_y == 0 && out_data.dir_z == 0)
        else $error("zero segment with direction");
endmodule

bind polyline_segment_direction psd_checker u_psd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready),
    .out_data (out_if.data)
);
